>>> design/ssp_pkg.sv
// Shared types and constants for the spectrum smoother with peak decay.
`default_nettype none

package ssp_pkg;

   localparam int NUM_BINS_DEFAULT = 256;

   localparam int MAG_W       = 16;
   localparam int BIN_W       = 8;
   localparam int DT_W        = 17;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   localparam logic [DT_W-1:0] DT_MAX_US = 17'd100000;
   localparam logic [32:0]     Q32_ONE   = 33'h1_0000_0000;
   localparam logic [32:0]     Q32_HALF  = 33'h0_8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SMOOTH_RATE  = 3'd0,
      CSR_DZ_THRESHOLD = 3'd1,
      CSR_DZ_GAIN      = 3'd2,
      CSR_DECAY_ENABLE = 3'd3,
      CSR_DECAY_RATE   = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [BIN_W-1:0] bin_index;
      logic [DT_W-1:0]  frame_dt_us;
   } req_payload_type;

   typedef struct packed {
      logic [BIN_W-1:0] out_bin_index;
      logic [MAG_W-1:0] level;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] smooth_rate;
      logic [15:0] dead_zone_threshold;
      logic [31:0] dead_zone_gain;
      logic        decay_enable;
      logic [15:0] decay_rate;
   } cfg_type;

endpackage

`default_nettype wire

>>> design/ssp_csr.sv
// Configuration register file for the spectrum smoother.
`default_nettype none

module ssp_csr
   import ssp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SMOOTH_RATE:  cfg_ff.smooth_rate         <= csr_wdata;
            CSR_DZ_THRESHOLD: cfg_ff.dead_zone_threshold <= csr_wdata[15:0];
            CSR_DZ_GAIN:      cfg_ff.dead_zone_gain      <= csr_wdata;
            CSR_DECAY_ENABLE: cfg_ff.decay_enable        <= csr_wdata[0];
            CSR_DECAY_RATE:   cfg_ff.decay_rate          <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> design/ssp_level_ram.sv
// Per-bin level memory with registered read and a clearing pass after reset.
`default_nettype none

module ssp_level_ram
   import ssp_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(NUM_BINS)-1:0] rd_addr,
   output logic      [MAG_W-1:0]            rd_data,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(NUM_BINS)-1:0] wr_addr,
   input  wire logic [MAG_W-1:0]            wr_data,
   output logic                             clr_busy
);

   localparam int ADDR_W = $clog2(NUM_BINS);

   logic [MAG_W-1:0]  mem [NUM_BINS];
   logic [MAG_W-1:0]  rd_data_ff;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // one entry zeroed per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(NUM_BINS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

>>> design/ssp_datapath.sv
// Pipelined smoothing, dead-zone and peak-decay datapath with bin hazard check.
`default_nettype none

module ssp_datapath
   import ssp_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  cfg_type                          cfg,
   input  wire logic                        clr_busy,
   input  wire logic                        in_valid,
   input  req_payload_type                  in_data,
   output logic                             in_ready,
   output logic                             rd_en,
   output logic      [$clog2(NUM_BINS)-1:0] rd_addr,
   input  wire logic [MAG_W-1:0]            rd_data,
   output logic                             wr_en,
   output logic      [$clog2(NUM_BINS)-1:0] wr_addr,
   output logic      [MAG_W-1:0]            wr_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output rsp_payload_type                  out_data
);

   localparam int ADDR_W = $clog2(NUM_BINS);
   localparam int CMP_W  = ((ADDR_W > BIN_W) ? ADDR_W : BIN_W) + 1;
   localparam int NS     = 9;

   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic             inr;
   } tag_type;

   typedef struct packed {
      logic signed [17:0] d;
      logic               dz;
      logic [MAG_W-1:0]   decayed;
      logic [MAG_W-1:0]   old;
   } carry_type;

   // stage control
   logic [NS:1]   v_ff;
   logic [NS:0]   v_src;
   logic [NS+1:1] adv;
   tag_type       tag_ff  [1:NS];
   tag_type       tag_src [0:NS-1];
   logic          accept;
   logic          hazard;
   logic          inr_in;
   logic          out_valid_ff;

   always_comb begin
      adv[NS+1] = !out_valid_ff || out_ready;
      for (int i = NS; i >= 1; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign inr_in = CMP_W'(in_data.bin_index) < CMP_W'(NUM_BINS);

   // a bin still in flight has not been written back yet
   always_comb begin
      hazard = 1'b0;
      for (int i = 1; i <= NS; i++) begin
         if (v_ff[i] && tag_ff[i].inr && (tag_ff[i].bin == in_data.bin_index)) begin
            hazard = 1'b1;
         end
      end
   end

   assign in_ready = adv[1] && !hazard && !clr_busy;
   assign accept   = in_valid && in_ready;
   assign rd_en    = accept && inr_in;
   assign rd_addr  = ADDR_W'(in_data.bin_index);

   assign v_src = {v_ff, accept};

   always_comb begin
      tag_src[0].bin = in_data.bin_index;
      tag_src[0].inr = inr_in;
      for (int i = 1; i < NS; i++) begin
         tag_src[i] = tag_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 1; i <= NS; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_src[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= NS; i++) begin
         if (adv[i]) begin
            tag_ff[i] <= tag_src[i-1];
         end
      end
   end

   // stage 1: capture beat, memory read in flight
   logic [MAG_W-1:0] s1_mag_ff;
   logic [DT_W-1:0]  s1_dt_ff, s1_dt_in;

   assign s1_dt_in = (in_data.frame_dt_us > DT_MAX_US) ? DT_MAX_US : in_data.frame_dt_us;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_mag_ff <= in_data.magnitude;
         s1_dt_ff  <= s1_dt_in;
      end
   end

   // stage 2: dt products, change against stored level
   logic [48:0]        s2_alpha_prod_ff, s2_alpha_prod_in;
   logic [32:0]        s2_ratio_ff, s2_ratio_in;
   logic [MAG_W-1:0]   s2_old_ff;
   logic signed [16:0] s2_diff_ff, s2_diff_in;

   always_comb begin
      s2_alpha_prod_in = 49'(s1_dt_ff) * 49'(cfg.smooth_rate);
      s2_ratio_in      = 33'(s1_dt_ff) * 33'(cfg.decay_rate);
      s2_diff_in       = $signed({1'b0, s1_mag_ff}) - $signed({1'b0, rd_data});
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_alpha_prod_ff <= s2_alpha_prod_in;
         s2_ratio_ff      <= s2_ratio_in;
         s2_old_ff        <= rd_data;
         s2_diff_ff       <= s2_diff_in;
      end
   end

   // stage 3: cap alpha at 1.0 (1.0 when smooth_rate is 0), decay factor clamps at 0
   logic [32:0]        s3_alpha_ff, s3_alpha_in;
   logic [32:0]        s3_factor_ff, s3_factor_in;
   logic [MAG_W-1:0]   s3_old_ff;
   logic signed [16:0] s3_diff_ff;

   always_comb begin
      if (cfg.smooth_rate == '0) begin
         s3_alpha_in = Q32_ONE;
      end else if (s2_alpha_prod_ff > 49'(Q32_ONE)) begin
         s3_alpha_in = Q32_ONE;
      end else begin
         s3_alpha_in = s2_alpha_prod_ff[32:0];
      end
      if (s2_ratio_ff >= Q32_ONE) begin
         s3_factor_in = '0;
      end else begin
         s3_factor_in = Q32_ONE - s2_ratio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_alpha_ff  <= s3_alpha_in;
         s3_factor_ff <= s3_factor_in;
         s3_old_ff    <= s2_old_ff;
         s3_diff_ff   <= s2_diff_ff;
      end
   end

   // stage 4: alpha * (mag - old) and old * factor
   logic signed [50:0] s4_pd_ff, s4_pd_in;
   logic [48:0]        s4_pq_ff, s4_pq_in;
   logic [MAG_W-1:0]   s4_old_ff;

   always_comb begin
      s4_pd_in = $signed({1'b0, s3_alpha_ff}) * s3_diff_ff;
      s4_pq_in = 49'(s3_old_ff) * 49'(s3_factor_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_pd_ff  <= s4_pd_in;
         s4_pq_ff  <= s4_pq_in;
         s4_old_ff <= s3_old_ff;
      end
   end

   // stage 5: round, magnitude of change, dead-zone test
   carry_type          c_ff [5:8];
   carry_type          c5_in;
   logic [15:0]        s5_ad_ff, s5_ad_in;
   logic [51:0]        rnd_d;
   logic [49:0]        rnd_q;
   logic signed [17:0] d_abs;

   always_comb begin
      rnd_d       = {s4_pd_ff[50], s4_pd_ff} + 52'(Q32_HALF);
      rnd_q       = {1'b0, s4_pq_ff} + 50'(Q32_HALF);
      c5_in.d       = $signed(rnd_d[49:32]);
      c5_in.decayed = rnd_q[47:32];
      c5_in.old     = s4_old_ff;
      d_abs       = c5_in.d[17] ? -c5_in.d : c5_in.d;
      s5_ad_in    = d_abs[15:0];
      c5_in.dz      = (cfg.dead_zone_threshold != '0) && (s5_ad_in != '0) &&
                      (s5_ad_in < cfg.dead_zone_threshold);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         c_ff[5]  <= c5_in;
         s5_ad_ff <= s5_ad_in;
      end
      for (int i = 6; i <= 8; i++) begin
         if (adv[i]) begin
            c_ff[i] <= c_ff[i-1];
         end
      end
   end

   // stage 6: square of the change
   logic [31:0] s6_sq_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_sq_ff <= 32'(s5_ad_ff) * 32'(s5_ad_ff);
      end
   end

   // stage 7: scale by gain
   logic [63:0] s7_prod_ff;

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_prod_ff <= 64'(s6_sq_ff) * 64'(cfg.dead_zone_gain);
      end
   end

   // stage 8: round squared change
   logic [32:0] s8_m2_ff;
   logic [64:0] rnd_m;

   assign rnd_m = {1'b0, s7_prod_ff} + 65'(Q32_HALF);

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_m2_ff <= rnd_m[64:32];
      end
   end

   // stage 9: apply change to old level
   logic signed [34:0] s9_sum_ff, s9_sum_in;
   logic [MAG_W-1:0]   s9_decayed_ff;
   logic signed [34:0] old_s, m2_s;

   always_comb begin
      old_s = $signed({19'd0, c_ff[8].old});
      m2_s  = $signed({2'd0, s8_m2_ff});
      if (!c_ff[8].dz) begin
         s9_sum_in = old_s + 35'(c_ff[8].d);
      end else if (c_ff[8].d[17]) begin
         s9_sum_in = old_s - m2_s;
      end else begin
         s9_sum_in = old_s + m2_s;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         s9_sum_ff     <= s9_sum_in;
         s9_decayed_ff <= c_ff[8].decayed;
      end
   end

   // output stage: saturate, peak hold, write back
   rsp_payload_type  out_data_ff;
   logic [MAG_W-1:0] filt;
   logic [MAG_W-1:0] level_in;

   always_comb begin
      if (s9_sum_ff[34]) begin
         filt = '0;
      end else if (s9_sum_ff[33:16] != '0) begin
         filt = '1;
      end else begin
         filt = s9_sum_ff[15:0];
      end
      if (!tag_ff[NS].inr) begin
         level_in = '0;
      end else if (cfg.decay_enable && (s9_decayed_ff > filt)) begin
         level_in = s9_decayed_ff;
      end else begin
         level_in = filt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv[NS+1]) begin
         out_valid_ff <= v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NS+1] && v_ff[NS]) begin
         out_data_ff.out_bin_index <= tag_ff[NS].bin;
         out_data_ff.level         <= level_in;
      end
   end

   assign wr_en     = v_ff[NS] && adv[NS+1] && tag_ff[NS].inr;
   assign wr_addr   = ADDR_W'(tag_ff[NS].bin);
   assign wr_data   = level_in;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

>>> design/spectrum_smoother_peak_decay_top.sv
// Top level of the per-bin spectrum smoother with dead zone and peak decay.
//
// Takes one bin beat per cycle while req_ready is high and returns one result
// beat per input beat, in order. The work runs through a ten-register pipeline
// (dt products, alpha capping, the smoothing and decay multiplies, the
// dead-zone square and gain multiply, saturation and peak hold) with the level
// memory read at input and written back at the output register. A bin that is
// still in one of the nine stages ahead of write-back holds req_ready low until
// its level has been written; distinct bins stream at one beat per cycle while
// the output is not stalled. After reset the level memory is cleared, one entry
// per cycle, during which req_ready stays low; CSR writes are taken at any
// time. Bins at or above NUM_BINS leave the memory alone and report level 0.
`default_nettype none

module spectrum_smoother_peak_decay_top
   import ssp_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  req_payload_type             req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_payload_type             rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = $clog2(NUM_BINS);

   cfg_type           cfg;
   logic              clr_busy;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [MAG_W-1:0]  rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [MAG_W-1:0]  wr_data;

   ssp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssp_level_ram #(
      .NUM_BINS (NUM_BINS)
   ) u_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .clr_busy (clr_busy)
   );

   ssp_datapath #(
      .NUM_BINS (NUM_BINS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .clr_busy  (clr_busy),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (req_ready),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> tb/sv/spectrum_smoother_peak_decay_top_test.sv
// Self-checking testbench for the spectrum smoother with dead zone and peak decay.
module spectrum_smoother_peak_decay_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ssp_pkg::*;

   localparam int NUM_BINS     = NUM_BINS_DEFAULT;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_PCT     = 37;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the block's registers and per-bin levels
   cfg_type          smoother_cfg;
   logic [MAG_W-1:0] bin_level_copy [NUM_BINS];
   rsp_payload_type  pending_levels [$];

   int mismatch_count = 0;
   int idle_pct       = IDLE_PCT;
   int rx_hold_len    = 0;

   spectrum_smoother_peak_decay_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // new level of one bin, unsigned Q16.0, from its old level, the magnitude and dt
   function automatic logic [MAG_W-1:0] smooth_level(input logic [MAG_W-1:0] old,
                                                     input logic [MAG_W-1:0] mag,
                                                     input logic [DT_W-1:0]  dt_raw);
      longint unsigned dt, alpha, avg, ad, sq, ratio, factor, decayed;
      longint          d, filt;
      logic [MAG_W-1:0] level;
      dt = dt_raw;
      if (dt > DT_MAX_US) dt = DT_MAX_US;
      if (smoother_cfg.smooth_rate == 0) begin
         alpha = Q32_ONE;
      end else begin
         alpha = dt * smoother_cfg.smooth_rate;
         if (alpha > Q32_ONE) alpha = Q32_ONE;
      end
      avg = (alpha * mag + (Q32_ONE - alpha) * old + Q32_HALF) >> 32;
      d = longint'(avg) - longint'(old);
      if (smoother_cfg.dead_zone_threshold != 0) begin
         ad = (d < 0) ? -d : d;
         if (ad != 0 && ad < smoother_cfg.dead_zone_threshold) begin
            sq = (ad * ad * smoother_cfg.dead_zone_gain + Q32_HALF) >> 32;
            d = (d < 0) ? -longint'(sq) : longint'(sq);
         end
      end
      filt = longint'(old) + d;
      if (filt < 0) filt = 0;
      else if (filt > 65535) filt = 65535;
      level = filt[MAG_W-1:0];
      if (smoother_cfg.decay_enable) begin
         ratio = dt * smoother_cfg.decay_rate;
         factor = (ratio >= Q32_ONE) ? 64'd0 : Q32_ONE - ratio;
         decayed = (old * factor + Q32_HALF) >> 32;
         if (decayed > level) level = decayed[MAG_W-1:0];
      end
      return level;
   endfunction

   function automatic req_payload_type bin_beat(input int mag, input int bin, input int dt);
      req_payload_type b;
      b.magnitude   = mag[MAG_W-1:0];
      b.bin_index   = bin[BIN_W-1:0];
      b.frame_dt_us = dt[DT_W-1:0];
      return b;
   endfunction

   // half the time a magnitude close to the bin's level, so the dead zone gets hit
   function automatic req_payload_type make_bin(input int bin, input int dt);
      int span, mag;
      if ($urandom_range(1)) return bin_beat($urandom_range(0, 65535), bin, dt);
      span = (smoother_cfg.dead_zone_threshold != 0) ? smoother_cfg.dead_zone_threshold : 64;
      mag = int'(bin_level_copy[bin]) + int'($urandom_range(0, 2 * span)) - span;
      if (mag < 0) mag = 0;
      else if (mag > 65535) mag = 65535;
      return bin_beat(mag, bin, dt);
   endfunction

   function automatic int pick_dt();
      case ($urandom_range(3))
         0: return $urandom_range(15000, 18000);
         1: return $urandom_range(0, 1000);
         2: return $urandom_range(100000, 131071);
         default: return $urandom_range(0, 131071);
      endcase
   endfunction

   function automatic cfg_type phase_cfg(input int p);
      cfg_type c;
      longint unsigned g;
      case (p)
         0: c = '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF};
         1: c = '0;
         default: begin
            case ($urandom_range(4))
               0: c.smooth_rate = '0;
               1: c.smooth_rate = $urandom_range(1, 5000);
               2: c.smooth_rate = $urandom_range(1, 1 << 20);
               3: c.smooth_rate = $urandom();
               default: c.smooth_rate = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(3))
               0: c.dead_zone_threshold = '0;
               1: c.dead_zone_threshold = 16'($urandom_range(1, 2000));
               2: c.dead_zone_threshold = 16'($urandom_range(1, 65535));
               default: c.dead_zone_threshold = 16'hFFFF;
            endcase
            if (c.dead_zone_threshold != 0 && $urandom_range(3) != 0) begin
               g = 64'h1_0000_0000 / c.dead_zone_threshold;
               if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
               c.dead_zone_gain = g[31:0];
            end else begin
               c.dead_zone_gain = $urandom();
            end
            c.decay_enable = 1'($urandom_range(1));
            case ($urandom_range(3))
               0: c.decay_rate = '0;
               1: c.decay_rate = 16'($urandom_range(1, 100));
               2: c.decay_rate = 16'($urandom_range(0, 65535));
               default: c.decay_rate = 16'hFFFF;
            endcase
         end
      endcase
      return c;
   endfunction

   // only called with nothing in flight
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SMOOTH_RATE:  smoother_cfg.smooth_rate         = value;
         CSR_DZ_THRESHOLD: smoother_cfg.dead_zone_threshold = value[15:0];
         CSR_DZ_GAIN:      smoother_cfg.dead_zone_gain      = value;
         CSR_DECAY_ENABLE: smoother_cfg.decay_enable        = value[0];
         CSR_DECAY_RATE:   smoother_cfg.decay_rate          = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_cfg(input cfg_type c);
      write_reg(CSR_SMOOTH_RATE, c.smooth_rate);
      write_reg(CSR_DZ_THRESHOLD, {16'd0, c.dead_zone_threshold});
      write_reg(CSR_DZ_GAIN, c.dead_zone_gain);
      write_reg(CSR_DECAY_ENABLE, {31'd0, c.decay_enable});
      write_reg(CSR_DECAY_RATE, {16'd0, c.decay_rate});
   endtask

   // valid stays up from one beat to the next unless the sender idles
   task automatic send_bin(input req_payload_type item);
      rsp_payload_type want;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      want.out_bin_index = item.bin_index;
      want.level = '0;
      if (item.bin_index < NUM_BINS) begin
         want.level = smooth_level(bin_level_copy[item.bin_index], item.magnitude,
                                   item.frame_dt_us);
         bin_level_copy[item.bin_index] = want.level;
      end
      pending_levels.push_back(want);
   endtask

   // drop valid and wait for every outstanding result
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual bin %0d level %0d",
                     $time, rsp_data.out_bin_index, rsp_data.level);
            mismatch_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_data.out_bin_index !== want.out_bin_index) begin
               $display("%0t: out_bin_index mismatch, expected %0d, actual %0d",
                        $time, want.out_bin_index, rsp_data.out_bin_index);
               mismatch_count++;
            end
            if (rsp_data.level !== want.level) begin
               $display("%0t: level mismatch on bin %0d, expected %0d, actual %0d",
                        $time, want.out_bin_index, want.level, rsp_data.level);
               mismatch_count++;
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold when a test asks for one
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_len != 0) begin
            hold = rx_hold_len;
            rx_hold_len = 0;
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // alpha of one; extremes of every input field, long frames clamp
   task automatic test_passthrough();
      apply_cfg('0);
      send_bin(bin_beat(65535, 0, 0));
      send_bin(bin_beat(0, 0, 131071));
      send_bin(bin_beat(16384, 255, 100000));
      send_bin(bin_beat(43690, 170, 100001));
   endtask

   task automatic test_smoothing();
      settle();
      apply_cfg('{32'h0001_0000, 16'd0, 32'd0, 1'b0, 16'd0});
      send_bin(bin_beat(65535, 1, 1000));
      send_bin(bin_beat(65535, 1, 50000));
      send_bin(bin_beat(0, 1, 131071));
      settle();
      write_reg(CSR_SMOOTH_RATE, 32'hFFFF_FFFF);
      send_bin(bin_beat(30000, 2, 0));
      send_bin(bin_beat(30000, 2, 1));
   endtask

   // matched gain shrinks small steps; an oversized gain saturates both ways
   task automatic test_dead_zone();
      settle();
      apply_cfg('{32'd0, 16'd16384, 32'd262144, 1'b0, 16'd0});
      send_bin(bin_beat(1000, 3, 16600));
      send_bin(bin_beat(1000, 3, 16600));
      send_bin(bin_beat(40000, 3, 16600));
      send_bin(bin_beat(39990, 3, 16600));
      settle();
      write_reg(CSR_DZ_THRESHOLD, 32'h0000_FFFF);
      write_reg(CSR_DZ_GAIN, 32'hFFFF_FFFF);
      send_bin(bin_beat(300, 5, 16600));
      send_bin(bin_beat(65000, 5, 16600));
   endtask

   task automatic test_decay();
      settle();
      apply_cfg('{32'd0, 16'd0, 32'd0, 1'b1, 16'd100});
      send_bin(bin_beat(60000, 6, 16600));
      send_bin(bin_beat(0, 6, 16600));
      settle();
      write_reg(CSR_DECAY_RATE, 32'h0000_FFFF);
      send_bin(bin_beat(0, 6, 65536));
      send_bin(bin_beat(0, 6, 65537));
      send_bin(bin_beat(50000, 7, 0));
      settle();
      // writes to unused indexes must leave the registers alone
      for (int i = CSR_DECAY_RATE + 1; i < (1 << CSR_INDEX_W); i++)
         write_reg(CSR_INDEX_W'(i), 32'hFFFF_FFFF);
      send_bin(bin_beat(0, 7, 100000));
   endtask

   // frames of consecutive bins with one dt each, mixed with noise on a few bins
   task automatic test_random_frames(input int phases, input int per_phase);
      int sent, len, base, dt;
      for (int p = 0; p < phases; p++) begin
         settle();
         apply_cfg(phase_cfg(p));
         idle_pct = (p == 2) ? 0 : IDLE_PCT;
         sent = 0;
         while (sent < per_phase) begin
            if ($urandom_range(9) < 7) begin
               dt   = pick_dt();
               len  = $urandom_range(1, 48);
               base = $urandom_range(0, NUM_BINS - 1);
               for (int k = 0; k < len && sent < per_phase; k++) begin
                  send_bin(make_bin((base + k) % NUM_BINS, dt));
                  sent++;
               end
            end else begin
               send_bin(bin_beat($urandom_range(0, 65535), $urandom_range(0, 3),
                                 $urandom_range(0, 131071)));
               sent++;
            end
         end
      end
      settle();
      idle_pct = IDLE_PCT;
   endtask

   // long receiver hold while the sender keeps offering beats
   task automatic test_backpressure();
      settle();
      apply_cfg(phase_cfg(2));
      idle_pct = 0;
      rx_hold_len = 300;
      for (int k = 0; k < 60; k++)
         send_bin(make_bin((k * 7) % NUM_BINS, 16600));
      settle();
      idle_pct = IDLE_PCT;
   endtask

   // sender stops until every result is back, then resumes on the same bins
   task automatic test_pause_resume();
      for (int k = 0; k < 20; k++)
         send_bin(make_bin(k, 16600));
      settle();
      for (int k = 0; k < 20; k++)
         send_bin(make_bin(k, 16600));
      settle();
   endtask

   initial begin
      smoother_cfg = '0;
      foreach (bin_level_copy[i]) bin_level_copy[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_passthrough();
      test_smoothing();
      test_dead_zone();
      test_decay();
      test_random_frames(8, 120);
      test_backpressure();
      test_pause_resume();

      settle();
      if (pending_levels.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> files.f
design/ssp_pkg.sv
design/ssp_csr.sv
design/ssp_level_ram.sv
design/ssp_datapath.sv
design/spectrum_smoother_peak_decay_top.sv
tb/sv/spectrum_smoother_peak_decay_top_test.sv
